@@ src/gcpr_pkg.sv @@
// gcpr_pkg: beat types, op codes and result types for the grouped complex
// product reduction block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gcpr_pkg;

  localparam int DATA_W = 32;
  localparam int GRP_W  = 8;

  localparam logic [1:0] OP_MUL   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // 1.0 in signed Q1.30
  localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh4000_0000;
  localparam logic signed [DATA_W-1:0] Q_ZERO = 32'sh0000_0000;

  typedef struct packed {
    logic [1:0]               op;
    logic [GRP_W-1:0]         group;
    logic signed [DATA_W-1:0] in_real;
    logic signed [DATA_W-1:0] in_imag;
  } in_item_t;

  typedef struct packed {
    logic [GRP_W-1:0]         out_group;
    logic signed [DATA_W-1:0] out_real;
    logic signed [DATA_W-1:0] out_imag;
    logic                     saturated;
  } out_item_t;

  // result of one complex multiply
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     sat;
  } cmul_res_t;

endpackage : gcpr_pkg

`default_nettype wire

@@ src/grouped_complex_product_reduce.sv @@
// grouped_complex_product_reduce: per-group complex product accumulators in
// one synchronous memory with per-group valid bits. Depends on gcpr_pkg and gcpr_cmul.
//
//   channel | ports                        | beat
//   input   | in_valid, in_ready, in_data  | in_item_t: op, group, in_real, in_imag
//   output  | out_valid, out_ready, out_data | out_item_t: group, real, imag, saturated
//
// One item at a time. A multiply goes through memory read, four products on the
// shared 32x32 multiplier, round and write back before the next accept. Read
// and clear go through memory read and result.
// Reset clears all valid bits at once; no clearing pass.
// The output register holds a stalled result while the next beat is taken;
// a finished item waits only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module grouped_complex_product_reduce #(
  parameter int GROUPS = 256
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire gcpr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output gcpr_pkg::out_item_t out_data
);
  import gcpr_pkg::*;

  // the 8-bit group field reaches at most 256 entries
  localparam int DEPTH = (GROUPS < 256) ? GROUPS : 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_OUT
  } state_t;

  state_t             state_r;
  in_item_t           item_r;
  logic [DEPTH-1:0]   valid_r;
  logic [63:0]        mem [DEPTH];
  logic [63:0]        rdata_r;
  logic signed [31:0] res_re_r, res_im_r;
  logic               res_sat_r;
  logic               wr_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept;
  logic               rd_en;
  logic [IDX_W-1:0]   idx_in, idx_r;
  logic               in_range_r;
  logic               hit;
  logic signed [31:0] cur_re, cur_im;
  logic               fire;
  logic               cm_start;
  logic               cm_done;
  cmul_res_t          cm_res;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign idx_in   = in_data.group[IDX_W-1:0];
  assign rd_en    = accept && (32'(in_data.group) < GROUPS);

  assign idx_r      = item_r.group[IDX_W-1:0];
  assign in_range_r = 32'(item_r.group) < GROUPS;
  assign hit        = in_range_r && valid_r[idx_r];
  assign cur_re     = hit ? rdata_r[63:32] : Q_ONE;
  assign cur_im     = hit ? rdata_r[31:0]  : Q_ZERO;

  assign cm_start = (state_r == S_FETCH) && (item_r.op == OP_MUL) && in_range_r;
  // the write back lands before the next read can be issued
  assign fire     = (state_r == S_OUT) && (!out_valid_r || out_ready);

  gcpr_cmul u_cmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cm_start),
    .a     (cur_re),
    .b     (cur_im),
    .c     (item_r.in_real),
    .d     (item_r.in_imag),
    .done  (cm_done),
    .res   (cm_res)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[idx_in];
    end
    if (fire && wr_r) begin
      mem[idx_r] <= {res_re_r, res_im_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      wr_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // load on fire, drop once taken
      out_valid_r <= fire || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_data;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (cm_start) begin
            state_r <= S_MUL;
          end else begin
            // read, unused code, clear or group out of range
            res_re_r  <= (item_r.op == OP_CLEAR) ? Q_ONE  : cur_re;
            res_im_r  <= (item_r.op == OP_CLEAR) ? Q_ZERO : cur_im;
            res_sat_r <= 1'b0;
            wr_r      <= 1'b0;
            state_r   <= S_OUT;
          end
        end
        S_MUL: begin
          if (cm_done) begin
            res_re_r  <= cm_res.re;
            res_im_r  <= cm_res.im;
            res_sat_r <= cm_res.sat;
            wr_r      <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (fire) begin
            out_data_r.out_group <= item_r.group;
            out_data_r.out_real  <= res_re_r;
            out_data_r.out_imag  <= res_im_r;
            out_data_r.saturated <= res_sat_r;
            if (item_r.op == OP_CLEAR) begin
              valid_r <= '0;
            end else if (wr_r) begin
              valid_r[idx_r] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : grouped_complex_product_reduce

`default_nettype wire

@@ src/gcpr_cmul.sv @@
// gcpr_cmul: complex multiply (a+bi)*(c+di) in Q1.30 on one shared 32x32
// multiplier, four products in turn, then round to nearest and saturate.
// Depends on gcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcpr_cmul (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire logic signed [31:0]  a,
  input  wire logic signed [31:0]  b,
  input  wire logic signed [31:0]  c,
  input  wire logic signed [31:0]  d,
  output logic                     done,
  output gcpr_pkg::cmul_res_t      res
);
  import gcpr_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [2:0]         cnt_r;
  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic signed [31:0] mx, my;
  logic signed [63:0] prod_r;
  logic signed [63:0] hold_r;
  logic signed [64:0] sum_re_r;
  logic signed [64:0] sum_im_r;
  cmul_res_t          res_r;
  logic [32:0]        rnd_re, rnd_im;

  // round half up on bit 29 and clip to 32 bits; returns {sat, value}
  function automatic logic [32:0] round_sat(input logic signed [64:0] s);
    logic signed [65:0] t;
    logic               ovf;
    t   = ($signed({s[64], s}) + 66'sd536870912) >>> 30;
    ovf = !((&t[65:31]) || (~|t[65:31]));
    if (ovf) begin
      round_sat = {1'b1, t[65] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end else begin
      round_sat = {1'b0, t[31:0]};
    end
  endfunction

  // product order: a*c, b*d, a*d, b*c
  assign mx = cnt_r[0] ? b_r : a_r;
  assign my = (cnt_r == 3'd0 || cnt_r == 3'd3) ? c_r : d_r;

  assign rnd_re = round_sat(sum_re_r);
  assign rnd_im = round_sat(sum_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 3'd5);
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        c_r    <= c;
        d_r    <= d;
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        prod_r <= mx * my;
        cnt_r  <= cnt_r + 3'd1;
        unique case (cnt_r)
          3'd1: hold_r <= prod_r;
          3'd2: sum_re_r <= {hold_r[63], hold_r} - {prod_r[63], prod_r};
          3'd3: hold_r <= prod_r;
          3'd4: sum_im_r <= {hold_r[63], hold_r} + {prod_r[63], prod_r};
          3'd5: begin
            res_r.re  <= rnd_re[31:0];
            res_r.im  <= rnd_im[31:0];
            res_r.sat <= rnd_re[32] | rnd_im[32];
            busy_r    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule : gcpr_cmul

`default_nettype wire

@@ src/gcpr_checker.sv @@
// gcpr_checker: port-level assertions for grouped_complex_product_reduce,
// bound to the top level. Depends on gcpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcpr_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire gcpr_pkg::in_item_t  in_data,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire gcpr_pkg::out_item_t out_data
);
  import gcpr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result beat without an item in flight");

  a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.out_real == 32'sh7FFF_FFFF) || (out_data.out_real == 32'sh8000_0000) ||
      (out_data.out_imag == 32'sh7FFF_FFFF) || (out_data.out_imag == 32'sh8000_0000))
    else $error("saturated flag set without a clipped part");

endmodule : gcpr_checker

bind grouped_complex_product_reduce gcpr_checker u_gcpr_checker (.*);

`default_nettype wire
